/* hw/rtl/rmle_pkg.sv */
package rmle_pkg;

    // Register file slots, in the order B, C, D, E, H, L, A
    localparam int NUM_REGS = 7;
    localparam logic [2:0] SLOT_H = 3'd4;
    localparam logic [2:0] SLOT_L = 3'd5;
    localparam logic [2:0] SLOT_A = 3'd6;

    // Register code that selects the byte at HL instead of a register
    localparam logic [2:0] CODE_MEM = 3'd6;
    localparam logic [2:0] CODE_A   = 3'd7;

    // Opcodes
    localparam logic [7:0] OPC_LOAD_FIRST = 8'h40;
    localparam logic [7:0] OPC_LOAD_LAST  = 8'h7F;
    localparam logic [7:0] OPC_LOGIC_FIRST = 8'hA0;
    localparam logic [7:0] OPC_LOGIC_LAST  = 8'hB7;
    localparam logic [7:0] OPC_AND_IMM = 8'hE6;
    localparam logic [7:0] OPC_XOR_IMM = 8'hEE;
    localparam logic [7:0] OPC_OR_IMM  = 8'hF6;

    // Logic group selector, opcode bits 4:3
    localparam logic [1:0] GRP_AND = 2'd0;
    localparam logic [1:0] GRP_XOR = 2'd1;

    // Flag bit positions
    localparam int FLAG_C  = 0;
    localparam int FLAG_N  = 1;
    localparam int FLAG_P  = 2;
    localparam int FLAG_F3 = 3;
    localparam int FLAG_H  = 4;
    localparam int FLAG_F5 = 5;
    localparam int FLAG_Z  = 6;
    localparam int FLAG_S  = 7;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_AND,
        OP_XOR,
        OP_OR
    } t_op_kind;

    // Decoded instruction handed from the front to the back
    typedef struct packed {
        t_op_kind   kind;
        logic [2:0] src_slot;
        logic [2:0] dst_slot;
        logic       use_mem;
        logic       unknown;
        logic [7:0] operand;
    } t_uop;

endpackage

/* hw/rtl/rmle_if.sv */
interface rmle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] opcode;
    logic [7:0] mem_operand;

    modport source (output valid, output opcode, output mem_operand, input ready);
    modport sink   (input valid, input opcode, input mem_operand, output ready);
endinterface

interface rmle_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  reg_a;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic [7:0]  flag_byte;
    logic [15:0] hl_address;
    logic        used_memory;
    logic        unknown_op;

    modport source (
        output valid, output reg_a, output reg_b, output reg_c, output reg_d,
        output reg_e, output reg_h, output reg_l, output flag_byte,
        output hl_address, output used_memory, output unknown_op,
        input ready
    );
    modport sink (
        input valid, input reg_a, input reg_b, input reg_c, input reg_d,
        input reg_e, input reg_h, input reg_l, input flag_byte,
        input hl_address, input used_memory, input unknown_op,
        output ready
    );
endinterface

/* hw/rtl/rmle_front.sv */
module rmle_front
    import rmle_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    rmle_in_if.sink      i_in,
    output logic         o_push_valid,
    input  logic         i_push_ready,
    output t_uop         o_uop
);

    logic r_valid;
    t_uop r_uop;
    t_uop n_uop;
    logic accept;

    assign i_in.ready   = !r_valid || i_push_ready;
    assign accept       = i_in.valid && i_in.ready;
    assign o_push_valid = r_valid;
    assign o_uop        = r_uop;

    always_comb begin
        logic [2:0] src;
        logic [2:0] dst;
        src = i_in.opcode[2:0];
        dst = i_in.opcode[5:3];

        n_uop          = '0;
        n_uop.kind     = OP_NOP;
        n_uop.operand  = i_in.mem_operand;
        n_uop.src_slot = (src == CODE_A) ? SLOT_A : src;
        n_uop.dst_slot = (dst == CODE_A) ? SLOT_A : dst;

        case (i_in.opcode) inside
            [OPC_LOAD_FIRST:OPC_LOAD_LAST]: begin
                if (src != CODE_MEM && dst != CODE_MEM) begin
                    n_uop.kind = OP_LOAD;
                end else begin
                    n_uop.unknown = 1'b1;
                end
            end
            [OPC_LOGIC_FIRST:OPC_LOGIC_LAST]: begin
                case (i_in.opcode[4:3])
                    GRP_AND: n_uop.kind = OP_AND;
                    GRP_XOR: n_uop.kind = OP_XOR;
                    default: n_uop.kind = OP_OR;
                endcase
                n_uop.use_mem = (src == CODE_MEM);
            end
            OPC_AND_IMM: begin
                n_uop.kind    = OP_AND;
                n_uop.use_mem = 1'b1;
            end
            OPC_XOR_IMM: begin
                n_uop.kind    = OP_XOR;
                n_uop.use_mem = 1'b1;
            end
            OPC_OR_IMM: begin
                n_uop.kind    = OP_OR;
                n_uop.use_mem = 1'b1;
            end
            default: begin
                n_uop.unknown = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_uop <= n_uop;
        end
    end

endmodule

/* hw/rtl/rmle_queue.sv */
module rmle_queue
    import rmle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_uop i_uop,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_uop o_uop
);

    t_uop       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_uop        = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_uop;
        end
    end

endmodule

/* hw/rtl/rmle_back.sv */
module rmle_back
    import rmle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_uop_valid,
    output logic        o_uop_ready,
    input  t_uop        i_uop,
    rmle_out_if.source  o_out
);

    logic [7:0] r_regs [NUM_REGS];
    logic [7:0] r_flags;
    logic [7:0] n_regs [NUM_REGS];
    logic [7:0] n_flags;
    logic       r_out_valid;
    logic [7:0] r_out_regs [NUM_REGS];
    logic [7:0] r_out_flags;
    logic [15:0] r_out_hl;
    logic       r_out_used;
    logic       r_out_unknown;
    logic       exec;
    logic [7:0] src_val;
    logic [7:0] result;

    assign o_uop_ready = !r_out_valid || o_out.ready;
    assign exec        = i_uop_valid && o_uop_ready;
    assign src_val     = i_uop.use_mem ? i_uop.operand : r_regs[i_uop.src_slot];

    always_comb begin
        n_regs  = r_regs;
        n_flags = r_flags;
        result  = '0;
        case (i_uop.kind)
            OP_LOAD: begin
                n_regs[i_uop.dst_slot] = src_val;
            end
            OP_AND, OP_XOR, OP_OR: begin
                case (i_uop.kind)
                    OP_AND:  result = r_regs[SLOT_A] & src_val;
                    OP_XOR:  result = r_regs[SLOT_A] ^ src_val;
                    default: result = r_regs[SLOT_A] | src_val;
                endcase
                n_regs[SLOT_A]   = result;
                n_flags          = '0;
                n_flags[FLAG_S]  = result[7];
                n_flags[FLAG_Z]  = (result == 8'd0);
                n_flags[FLAG_F5] = result[5];
                n_flags[FLAG_H]  = (i_uop.kind == OP_AND);
                n_flags[FLAG_F3] = result[3];
                n_flags[FLAG_P]  = ~^result;
                n_flags[FLAG_N]  = 1'b0;
                n_flags[FLAG_C]  = 1'b0;
            end
            default: begin
                n_regs  = r_regs;
                n_flags = r_flags;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= 8'd0;
            end
            r_flags     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec) begin
                r_regs  <= n_regs;
                r_flags <= n_flags;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out_regs    <= n_regs;
            r_out_flags   <= n_flags;
            r_out_hl      <= {r_regs[SLOT_H], r_regs[SLOT_L]};
            r_out_used    <= i_uop.use_mem && (i_uop.kind != OP_NOP);
            r_out_unknown <= i_uop.unknown;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.reg_b       = r_out_regs[0];
    assign o_out.reg_c       = r_out_regs[1];
    assign o_out.reg_d       = r_out_regs[2];
    assign o_out.reg_e       = r_out_regs[3];
    assign o_out.reg_h       = r_out_regs[SLOT_H];
    assign o_out.reg_l       = r_out_regs[SLOT_L];
    assign o_out.reg_a       = r_out_regs[SLOT_A];
    assign o_out.flag_byte   = r_out_flags;
    assign o_out.hl_address  = r_out_hl;
    assign o_out.used_memory = r_out_used;
    assign o_out.unknown_op  = r_out_unknown;

endmodule

/* hw/rtl/register_move_and_logic_executor.sv */
// An item passes the decode register, a queue slot and the result register, in
//   that order, before its result can be taken; a stalled output holds it there.
// Throughput: one item per cycle while the output is not stalled; the register
//   file and logic unit finish an instruction in the cycle it leaves the queue.
// Reset (i_rst_n low, synchronous): all seven registers and the flag byte clear
//   to zero; the decode stage, queue and result register empty.
module register_move_and_logic_executor
    import rmle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmle_in_if.sink     i_in,
    rmle_out_if.source  o_out
);

    // Front to queue: decoded instruction with its own handshake
    logic q_push_valid;
    logic q_push_ready;
    t_uop q_push_uop;

    // Queue to back
    logic q_pop_valid;
    logic q_pop_ready;
    t_uop q_pop_uop;

    // Front: take the item, classify the opcode into a load, a logic op or a
    // no-op, translate register codes into register file slots, and hold the
    // decoded item until the queue has room.
    rmle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (q_push_valid),
        .i_push_ready (q_push_ready),
        .o_uop        (q_push_uop)
    );

    // Two-entry queue: lets decode keep accepting while the back waits on
    // the output, and lets the back drain while no new item arrives.
    rmle_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_valid),
        .o_push_ready (q_push_ready),
        .i_uop        (q_push_uop),
        .o_pop_valid  (q_pop_valid),
        .i_pop_ready  (q_pop_ready),
        .o_uop        (q_pop_uop)
    );

    // Back: own the register file and flags, execute in program order, and
    // advance a result into the output register whenever that register is
    // empty or being taken in the same cycle. HL is captured before the
    // instruction updates it.
    rmle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop_valid (q_pop_valid),
        .o_uop_ready (q_pop_ready),
        .i_uop       (q_pop_uop),
        .o_out       (o_out)
    );

endmodule
